// ===== design/bdcd_pkg.sv =====
// Package for the button debounce and click detector.
// Holds shared widths, register map, event codes, press states and the
// config/result types. No dependencies.
`timescale 1ns / 1ps

package bdcd_pkg;

   localparam int TIME_BITS   = 16;
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = QPTR_BITS + 1;
   localparam int ADDR_BITS   = 5;
   localparam int DATA_BITS   = 32;

   // register indexes (byte address = 4 * index)
   localparam logic [2:0] REG_ENABLE       = 3'd0;
   localparam logic [2:0] REG_INVERT_LEVEL = 3'd1;
   localparam logic [2:0] REG_DEBOUNCE_MS  = 3'd2;
   localparam logic [2:0] REG_PRESS_MS     = 3'd3;
   localparam logic [2:0] REG_LONG_MS      = 3'd4;
   localparam logic [2:0] REG_LONGER_MS    = 3'd5;
   localparam logic [2:0] REG_REPEAT_LIMIT = 3'd6;

   localparam logic [2:0] EV_PRESS        = 3'd0;
   localparam logic [2:0] EV_LONG_START   = 3'd1;
   localparam logic [2:0] EV_LONG_STOP    = 3'd2;
   localparam logic [2:0] EV_LONGER_START = 3'd3;
   localparam logic [2:0] EV_LONGER_STOP  = 3'd4;

   // press machine states
   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_HELD     = 3'd1;
   localparam logic [2:0] ST_RELEASED = 3'd2;
   localparam logic [2:0] ST_LONG     = 3'd3;
   localparam logic [2:0] ST_LONGER   = 3'd4;

   typedef struct packed {
      logic        enable;
      logic        invert_level;
      logic [15:0] debounce_ms;
      logic [15:0] press_ms;
      logic [15:0] long_press_ms;
      logic [15:0] longer_press_ms;
      logic [7:0]  repeat_limit;
   } cfg_type;

   typedef struct packed {
      logic [2:0] event_code;
      logic [7:0] repeat_count;
      logic       last;
   } result_type;

   // results of one tick, handed from the step logic to the queue
   typedef struct packed {
      logic       in_flight;
      logic [1:0] count;
      result_type ev0;
      result_type ev1;
   } step_out_type;

endpackage

// ===== design/bdcd_csr.sv =====
// Configuration registers of the button debounce and click detector.
// APB-style write and read-back; depends on bdcd_pkg.
`timescale 1ns / 1ps

module bdcd_csr import bdcd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   output logic [DATA_BITS-1:0] prdata,
   output logic                 pready,
   output cfg_type              cfg
);

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[4:2];
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable          <= 1'b0;
         cfg_ff.invert_level    <= 1'b0;
         cfg_ff.debounce_ms     <= 16'd20;
         cfg_ff.press_ms        <= 16'd300;
         cfg_ff.long_press_ms   <= 16'd500;
         cfg_ff.longer_press_ms <= 16'd5000;
         cfg_ff.repeat_limit    <= 8'd2;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_ENABLE:       cfg_ff.enable          <= pwdata[0];
            REG_INVERT_LEVEL: cfg_ff.invert_level    <= pwdata[0];
            REG_DEBOUNCE_MS:  cfg_ff.debounce_ms     <= pwdata[15:0];
            REG_PRESS_MS:     cfg_ff.press_ms        <= pwdata[15:0];
            REG_LONG_MS:      cfg_ff.long_press_ms   <= pwdata[15:0];
            REG_LONGER_MS:    cfg_ff.longer_press_ms <= pwdata[15:0];
            REG_REPEAT_LIMIT: cfg_ff.repeat_limit    <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_idx)
         REG_ENABLE:       prdata = {31'd0, cfg_ff.enable};
         REG_INVERT_LEVEL: prdata = {31'd0, cfg_ff.invert_level};
         REG_DEBOUNCE_MS:  prdata = {16'd0, cfg_ff.debounce_ms};
         REG_PRESS_MS:     prdata = {16'd0, cfg_ff.press_ms};
         REG_LONG_MS:      prdata = {16'd0, cfg_ff.long_press_ms};
         REG_LONGER_MS:    prdata = {16'd0, cfg_ff.longer_press_ms};
         REG_REPEAT_LIMIT: prdata = {24'd0, cfg_ff.repeat_limit};
         default:          prdata = '0;
      endcase
   end

endmodule

// ===== design/bdcd_step.sv =====
// Per-tick logic: input register, debouncer and five-state press machine.
// Emits up to two results per tick; depends on bdcd_pkg.
`timescale 1ns / 1ps

module bdcd_step import bdcd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         in_valid,
   input  logic         in_level,
   output step_out_type step_out
);

   localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

   logic                 in_v_ff, in_level_ff;
   logic                 busy_ff, busy_in;
   logic                 cand_ff, cand_in;
   logic                 stable_ff, stable_in;
   logic [TIME_BITS-1:0] deb_ff, deb_in;
   logic [2:0]           state_ff, state_in;
   logic [TIME_BITS-1:0] pel_ff, pel_in;
   logic                 pend_ff, pend_in;
   logic                 pend_press_ff, pend_press_in;
   logic [7:0]           rep_ff, rep_in;

   logic                 active, level;
   logic [TIME_BITS-1:0] pel_inc, deb_inc;
   logic [1:0]           n_res;
   logic [2:0]           code0, code1;
   logic                 last0;

   assign active  = in_v_ff & cfg.enable;
   assign level   = in_level_ff ^ cfg.invert_level;
   assign pel_inc = (pel_ff == TIME_MAX) ? pel_ff : pel_ff + 1'b1;
   assign deb_inc = (deb_ff == TIME_MAX) ? deb_ff : deb_ff + 1'b1;

   always_ff @(posedge clock) begin
      in_level_ff <= in_level;
      if (reset) begin
         in_v_ff <= 1'b0;
      end else begin
         in_v_ff <= in_valid;
      end
   end

   always_comb begin
      busy_in       = busy_ff;
      cand_in       = cand_ff;
      stable_in     = stable_ff;
      deb_in        = deb_ff;
      pel_in        = pel_ff;
      pend_in       = pend_ff;
      pend_press_in = pend_press_ff;
      state_in      = state_ff;
      rep_in        = rep_ff;
      n_res         = 2'd0;
      code0         = EV_PRESS;
      code1         = EV_LONGER_STOP;
      last0         = 1'b1;

      if (active) begin
         pel_in = pel_inc;

         // debouncer
         if (!busy_ff) begin
            if (level != stable_ff) begin
               busy_in = 1'b1;
               cand_in = level;
               deb_in  = '0;
            end
         end else if (level == cand_ff) begin
            deb_in = deb_inc;
            if (32'(deb_inc) >= 32'(cfg.debounce_ms)) begin
               stable_in     = level;
               pend_in       = 1'b1;
               pend_press_in = level;
               pel_in        = '0;
               busy_in       = 1'b0;
            end
         end else begin
            busy_in = 1'b0;
         end

         // press machine
         unique case (state_ff)
            ST_IDLE: begin
               if (pend_in && pend_press_in) begin
                  pend_in  = 1'b0;
                  state_in = ST_HELD;
               end
            end
            ST_HELD: begin
               if (pend_in && !pend_press_in) begin
                  pend_in  = 1'b0;
                  state_in = ST_RELEASED;
               end else if (32'(pel_in) > 32'(cfg.long_press_ms)) begin
                  n_res    = 2'd1;
                  code0    = EV_LONG_START;
                  state_in = ST_LONG;
               end
            end
            ST_LONG: begin
               if (pend_in) begin
                  n_res    = 2'd1;
                  code0    = EV_LONG_STOP;
                  pend_in  = 1'b0;
                  state_in = ST_IDLE;
                  rep_in   = '0;
               end else if (32'(pel_in) > 32'(cfg.longer_press_ms)) begin
                  n_res    = 2'd1;
                  code0    = EV_LONGER_START;
                  state_in = ST_LONGER;
               end
            end
            ST_LONGER: begin
               // two beats: long stop, then longer stop marked last
               if (pend_in) begin
                  n_res    = 2'd2;
                  code0    = EV_LONG_STOP;
                  last0    = 1'b0;
                  pend_in  = 1'b0;
                  state_in = ST_IDLE;
                  rep_in   = '0;
               end
            end
            ST_RELEASED: begin
               if (pend_in && pend_press_in) begin
                  pend_in = 1'b0;
                  if (rep_ff < cfg.repeat_limit) begin
                     state_in = ST_HELD;
                     rep_in   = rep_ff + 1'b1;
                  end else begin
                     n_res    = 2'd1;
                     code0    = EV_PRESS;
                     state_in = ST_IDLE;
                     rep_in   = '0;
                  end
               end else if (32'(pel_in) > 32'(cfg.press_ms)) begin
                  n_res    = 2'd1;
                  code0    = EV_PRESS;
                  state_in = ST_IDLE;
                  rep_in   = '0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         cand_ff       <= 1'b0;
         stable_ff     <= 1'b0;
         deb_ff        <= '0;
         state_ff      <= ST_IDLE;
         pel_ff        <= '0;
         pend_ff       <= 1'b0;
         pend_press_ff <= 1'b0;
         rep_ff        <= '0;
      end else begin
         busy_ff       <= busy_in;
         cand_ff       <= cand_in;
         stable_ff     <= stable_in;
         deb_ff        <= deb_in;
         state_ff      <= state_in;
         pel_ff        <= pel_in;
         pend_ff       <= pend_in;
         pend_press_ff <= pend_press_in;
         rep_ff        <= rep_in;
      end
   end

   // repeat count reported is the value held before this tick
   assign step_out.in_flight        = in_v_ff;
   assign step_out.count            = n_res;
   assign step_out.ev0.event_code   = code0;
   assign step_out.ev0.repeat_count = rep_ff;
   assign step_out.ev0.last         = last0;
   assign step_out.ev1.event_code   = code1;
   assign step_out.ev1.repeat_count = rep_ff;
   assign step_out.ev1.last         = 1'b1;

   a_idle_no_repeat: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (rep_ff == 8'd0))
      else $error("click count held while press machine idle");

   a_busy_differs: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cand_ff != stable_ff))
      else $error("debouncer busy on a level equal to the stable level");

   a_frozen_when_off: assert property (@(posedge clock) disable iff (reset)
      (in_v_ff && !cfg.enable) |=> ($stable(state_ff) && $stable(pel_ff)))
      else $error("state moved on a tick while disabled");

   a_two_only_from_longer: assert property (@(posedge clock) disable iff (reset)
      (n_res == 2'd2) |-> (state_ff == ST_LONGER))
      else $error("double result outside longer press");

endmodule

// ===== design/bdcd_rsp_queue.sv =====
// Result queue: takes up to two beats per cycle from the step logic into an
// eight-entry store behind an output register that drives the result channel;
// also produces the input stall. Uses bdcd_pkg.
`timescale 1ns / 1ps

module bdcd_rsp_queue import bdcd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  step_out_type step_out,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output result_type   rsp_data
);

   result_type           mem [QUEUE_DEPTH];
   result_type           out_ff;
   logic                 out_v_ff, out_v_in;
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 pop, load, mem_pop, bypass;
   logic [1:0]           wr_n;
   result_type           wr_first;
   logic [QPTR_BITS-1:0] wr_ptr_nx;

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;
   assign pop       = out_v_ff & ~rsp_stall;
   // output register is free after this edge
   assign load      = ~out_v_ff | pop;
   assign mem_pop   = load & (count_ff != '0);
   // store empty: first new beat goes straight to the output register
   assign bypass    = load & (count_ff == '0) & (step_out.count != 2'd0);
   assign wr_n      = bypass ? (step_out.count - 2'd1) : step_out.count;
   assign wr_first  = bypass ? step_out.ev1 : step_out.ev0;
   assign wr_ptr_nx = wr_ptr_ff + 1'b1;
   assign out_v_in  = load ? (mem_pop | bypass) : 1'b1;

   // leave room for the tick in flight and the one about to enter
   assign req_stall = step_out.in_flight ?
                      (count_ff > QCNT_BITS'(QUEUE_DEPTH - 4)) :
                      (count_ff > QCNT_BITS'(QUEUE_DEPTH - 2));

   assign wr_ptr_in = wr_ptr_ff + QPTR_BITS'(wr_n);
   assign rd_ptr_in = rd_ptr_ff + QPTR_BITS'(mem_pop);
   assign count_in  = count_ff + QCNT_BITS'(wr_n) - QCNT_BITS'(mem_pop);

   always_ff @(posedge clock) begin
      if (wr_n != 2'd0) begin
         mem[wr_ptr_ff] <= wr_first;
      end
      if (wr_n == 2'd2) begin
         mem[wr_ptr_nx] <= step_out.ev1;
      end
      if (mem_pop) begin
         out_ff <= mem[rd_ptr_ff];
      end else if (bypass) begin
         out_ff <= step_out.ev0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         out_v_ff  <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         out_v_ff  <= out_v_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (32'(count_ff) + 32'(wr_n) - 32'(mem_pop)) <= QUEUE_DEPTH)
      else $error("result queue overflow");

   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      QPTR_BITS'(wr_ptr_ff - rd_ptr_ff) == QPTR_BITS'(count_ff))
      else $error("queue pointers disagree with fill count");

   a_pop_advances: assert property (@(posedge clock) disable iff (reset)
      mem_pop |=> (rd_ptr_ff == QPTR_BITS'($past(rd_ptr_ff) + 1'b1)))
      else $error("read pointer did not advance on a taken beat");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result beat changed");

endmodule

// ===== design/button_debounce_click_detector.sv =====
// Button debouncer with multi-click, long-press and longer-press detection.
// Each req beat is one millisecond tick with the sampled pin level. A tick is
// taken every cycle while req_stall is low; its results (none, one, or two
// for a longer-press stop) pass through the input register and then the result
// output register before they appear on rsp. The result queue (eight beats
// behind the output register) sets the only limit: req_stall rises when it
// cannot hold the beats of the tick in flight and of one more tick, so a
// stalled rsp side throttles req once the queue fills. Program registers only
// while no ticks or results are in flight. Depends on bdcd_pkg.
`timescale 1ns / 1ps

module button_debounce_click_detector import bdcd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_pin_level,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_event_code,
   output logic [7:0]           rsp_repeat_count,
   output logic                 rsp_last,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   output logic [DATA_BITS-1:0] prdata,
   output logic                 pready
);

   cfg_type      cfg;
   step_out_type step_out;
   result_type   rsp_data;
   logic         req_take;

   assign req_take = req_valid & ~req_stall;

   bdcd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   bdcd_step u_step (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_valid (req_take),
      .in_level (req_pin_level),
      .step_out (step_out)
   );

   bdcd_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .step_out  (step_out),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_event_code   = rsp_data.event_code;
   assign rsp_repeat_count = rsp_data.repeat_count;
   assign rsp_last         = rsp_data.last;

endmodule
